// ===== rtl/lifo_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lifo_pkg: shared types for the LIFO stack with search
// Word formats of both channels, the decoded command handed from the front
// end to the execution unit, and the execution state encoding.
// ----------------------------------------------------------------------------
package lifo_pkg;

  // fixed field widths of the channel words
  localparam int OP_W    = 2;
  localparam int VAL_W   = 16;
  localparam int DEPTH_W = 6;
  localparam int COUNT_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_SEARCH = 2'd3
  } lifo_op_t;

  // input word
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] value;
  } lifo_in_t;

  // result word
  typedef struct packed {
    logic [VAL_W-1:0]   top_value;
    logic               underflow;
    logic               overflow;
    logic               found;
    logic [DEPTH_W-1:0] match_depth;
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;
  } lifo_out_t;

  // decoded command between front end and execution unit
  typedef struct packed {
    lifo_op_t         op;
    logic             is_read;   // pop or peek
    logic [VAL_W-1:0] value;
  } lifo_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_DONE
  } lifo_state_t;

endpackage
`default_nettype wire

// ===== rtl/lifo_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lifo_front: input acceptance and command queue
// Decodes each input word into a command and holds up to two commands so
// the input side keeps flowing while the execution unit is busy.
// ----------------------------------------------------------------------------
module lifo_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire lifo_pkg::lifo_in_t  in_data,
  output logic                     cmd_valid,
  input  wire logic                cmd_ready,
  output lifo_pkg::lifo_cmd_t      cmd_data
);
  import lifo_pkg::*;

  localparam logic [1:0] Q_FULL = 2'd2;

  lifo_cmd_t  q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  lifo_cmd_t  cmd_in;
  logic       q_push, q_pop;

  // decode
  always_comb begin
    cmd_in.op      = lifo_op_t'(in_data.op);
    cmd_in.value   = in_data.value;
    cmd_in.is_read = (cmd_in.op == OP_POP) || (cmd_in.op == OP_PEEK);
  end

  // queue handshake
  assign in_ready  = (cnt_r != Q_FULL);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd_data  = q_r[rd_ptr_r];
  assign q_push    = in_valid && in_ready;
  assign q_pop     = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = q_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(q_push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage, no reset needed
  always_ff @(posedge clk) begin
    if (q_push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lifo_exec.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lifo_exec: stack execution unit
// Holds the entry memory and fill count, runs push/pop/peek and the
// top-down search scan, and drives the registered result word.
// ----------------------------------------------------------------------------
module lifo_exec #(
  parameter int STACK_DEPTH = 64,
  parameter int VALUE_BITS  = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cmd_valid,
  output logic                                       cmd_ready,
  input  wire lifo_pkg::lifo_cmd_t                   cmd_data,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output lifo_pkg::lifo_out_t                        out_data,
  output logic [$clog2(STACK_DEPTH+1)-1:0]           fill_count
);
  import lifo_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);

  // entry memory
  logic [VALUE_BITS-1:0] mem [STACK_DEPTH];
  logic [VALUE_BITS-1:0] rd_data_r;
  logic [AW-1:0]         rd_addr;
  logic                  mem_we;

  lifo_state_t           state_r, state_nxt;
  logic [CW-1:0]         fill_r, fill_nxt;
  logic [AW-1:0]         ptr_r, ptr_nxt;
  logic [AW-1:0]         depth_r, depth_nxt;
  logic [VALUE_BITS-1:0] key_r, key_nxt;
  logic                  pop_r, pop_nxt;
  lifo_out_t             res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  lifo_out_t             out_data_r, out_data_nxt;

  logic [AW-1:0]         top_addr;
  logic [31:0]           wide_in;
  logic [VALUE_BITS-1:0] cmd_key;
  logic [31:0]           wide_rd;
  logic [31:0]           wide_depth;

  // width adaption of value and depth fields
  assign wide_in    = 32'(cmd_data.value);
  assign cmd_key    = wide_in[VALUE_BITS-1:0];
  assign wide_rd    = 32'(rd_data_r);
  assign wide_depth = 32'(depth_r);
  assign top_addr   = fill_r[AW-1:0] - AW'(1);

  // result word with count and empty flag filled in
  function automatic lifo_out_t with_count(lifo_out_t r, logic [CW-1:0] c);
    lifo_out_t   o;
    logic [31:0] wc;
    o             = r;
    wc            = 32'(c);
    o.entry_count = wc[COUNT_W-1:0];
    o.is_empty    = (c == '0);
    return o;
  endfunction

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    ptr_nxt       = ptr_r;
    depth_nxt     = depth_r;
    key_nxt       = key_r;
    pop_nxt       = pop_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    cmd_ready     = 1'b0;
    mem_we        = 1'b0;
    rd_addr       = top_addr;

    // result taken downstream
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          res_nxt = '0;
          if (cmd_data.is_read) begin
            if (fill_r == '0) begin
              res_nxt.underflow = 1'b1;
              res_nxt   = with_count(res_nxt, fill_r);
              state_nxt = ST_DONE;
            end else begin
              // top entry read issued this cycle
              pop_nxt   = (cmd_data.op == OP_POP);
              state_nxt = ST_READ;
            end
          end else if (cmd_data.op == OP_PUSH) begin
            if (fill_r == FULL_CNT) begin
              res_nxt.overflow = 1'b1;
              res_nxt = with_count(res_nxt, fill_r);
            end else begin
              mem_we   = 1'b1;
              fill_nxt = fill_r + CW'(1);
              res_nxt  = with_count(res_nxt, fill_nxt);
            end
            state_nxt = ST_DONE;
          end else begin
            if (fill_r == '0) begin
              res_nxt   = with_count(res_nxt, fill_r);
              state_nxt = ST_DONE;
            end else begin
              // topmost entry read now, next address queued
              key_nxt   = cmd_key;
              depth_nxt = '0;
              ptr_nxt   = top_addr - AW'(1);
              state_nxt = ST_SCAN;
            end
          end
        end
      end

      ST_READ: begin
        res_nxt.top_value = wide_rd[VAL_W-1:0];
        if (pop_r) begin
          fill_nxt = fill_r - CW'(1);
        end
        res_nxt   = with_count(res_nxt, fill_nxt);
        state_nxt = ST_DONE;
      end

      ST_SCAN: begin
        // one compare per cycle, next read overlapped
        rd_addr = ptr_r;
        if (rd_data_r == key_r) begin
          res_nxt.found       = 1'b1;
          res_nxt.match_depth = wide_depth[DEPTH_W-1:0];
          res_nxt   = with_count(res_nxt, fill_r);
          state_nxt = ST_DONE;
        end else if (depth_r == top_addr) begin
          res_nxt   = with_count(res_nxt, fill_r);
          state_nxt = ST_DONE;
        end else begin
          ptr_nxt   = ptr_r - AW'(1);
          depth_nxt = depth_r + AW'(1);
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    depth_r    <= depth_nxt;
    key_r      <= key_nxt;
    pop_r      <= pop_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fill_r[AW-1:0]] <= cmd_key;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign fill_count = fill_r;

endmodule
`default_nettype wire

// ===== rtl/lifo_stack_with_search_unit.sv =====
`default_nettype none
// Execution: one word executes at a time and holds the execution unit until its result
// is registered for output; pop/peek wait on a registered top-entry read, and search
// compares stored entries from the top down until a hit or the bottom entry.
// A result left untaken stalls the next word.
// Reset: synchronous active-low rst_n empties the stack and the 2-deep command queue;
// entry memory contents are not cleared.
// ----------------------------------------------------------------------------
// lifo_stack_with_search_unit: bounded LIFO stack with key search
// Push, pop, peek and top-down search over a memory-backed stack; every
// result word reports the entry count and empty flag after the operation.
// ----------------------------------------------------------------------------
module lifo_stack_with_search_unit #(
  parameter int STACK_DEPTH = 64,
  parameter int VALUE_BITS  = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire lifo_pkg::lifo_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output lifo_pkg::lifo_out_t      out_data
);
  import lifo_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic          cmd_valid;
  logic          cmd_ready;
  lifo_cmd_t     cmd_data;
  logic [CW-1:0] fill_count;

  // front end
  lifo_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data)
  );

  // execution unit
  lifo_exec #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd_data   (cmd_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fill_count (fill_count)
  );

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_count <= CW'(STACK_DEPTH))
    else $error("fill count above stack depth");

  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.underflow |-> out_data.is_empty && (out_data.top_value == '0))
    else $error("underflow word with entries or data");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow |-> !out_data.underflow && !out_data.found)
    else $error("overflow combined with other status");

  a_found_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> !out_data.is_empty)
    else $error("search hit on empty stack");

endmodule
`default_nettype wire
